// ===== rtl/spam_pkg.sv =====
// Shared constants, codes and control/status types for the sparse polynomial merge block.
package spam_pkg;

  localparam int TERMS_PER_POLY_DEF = 16;
  localparam int MAX_RESULTS = 32;

  localparam int CMD_W = 2;
  localparam int COEF_W = 32;
  localparam int EXPON_W = 16;
  localparam int STATUS_W = 2;
  localparam int TERM_W = COEF_W + EXPON_W;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] ST_TERM = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OK = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec_single;
    logic merge_init;
    logic merge_step;
    logic merge_final;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic both_done;
    logic term_hit;
    logic pend_vld;
    logic at_limit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/spam_in_if.sv =====
// Input channel interface: command and term payload with valid/ready handshake.
interface spam_in_if import spam_pkg::*; ();
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic signed [COEF_W-1:0] in_coef;
  logic [EXPON_W-1:0] in_expon;

  modport source (output valid, output cmd, output in_coef, output in_expon, input ready);
  modport sink (input valid, input cmd, input in_coef, input in_expon, output ready);
endinterface

// ===== rtl/spam_out_if.sv =====
// Result channel interface: result term, status and last flag with valid/ready handshake.
interface spam_out_if import spam_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [COEF_W-1:0] out_coef;
  logic [EXPON_W-1:0] out_expon;
  logic [STATUS_W-1:0] status;
  logic is_last;

  modport source (output valid, output out_coef, output out_expon, output status,
                  output is_last, input ready);
  modport sink (input valid, input out_coef, input out_expon, input status,
                input is_last, output ready);
endinterface

// ===== rtl/spam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/spam_dp.sv =====
// Datapath: term stores, counts, merge indices, pending term and output register.
module spam_dp import spam_pkg::*; #(
  parameter int TERMS_PER_POLY = TERMS_PER_POLY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd_i,
  output dp_stat_t                   stat_o,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [COEF_W-1:0]   in_coef,
  input  logic [EXPON_W-1:0]         in_expon,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [COEF_W-1:0]   out_coef,
  output logic [EXPON_W-1:0]         out_expon,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_last
);
  localparam int CNT_W = $clog2(TERMS_PER_POLY + 1);
  localparam int IDX_W = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TERMS_PER_POLY);
  localparam logic [NRES_W-1:0] N_LAST = NRES_W'(MAX_RESULTS - 1);

  logic [CMD_W-1:0]    cmd_r;
  logic [COEF_W-1:0]   coef_in_r;
  logic [EXPON_W-1:0]  expon_in_r;
  logic [CNT_W-1:0]    a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [NRES_W-1:0]   n_r, n_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [COEF_W-1:0]   pend_coef_r, pend_coef_nxt;
  logic [EXPON_W-1:0]  pend_expon_r, pend_expon_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [COEF_W-1:0]   out_coef_r, out_coef_nxt;
  logic [EXPON_W-1:0]  out_expon_r, out_expon_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic                a_we, b_we;
  logic [TERM_W-1:0]   a_rdata, b_rdata;
  logic [COEF_W-1:0]   a_coef, b_coef, sat_sum, term_coef;
  logic [EXPON_W-1:0]  a_expon, b_expon, term_expon;
  logic [COEF_W:0]     sum_full;
  logic                a_full, b_full, a_done, b_done;
  logic                take_a, take_b, take_both, term_hit, out_free;

  assign a_full = (a_cnt_r == CNT_FULL);
  assign b_full = (b_cnt_r == CNT_FULL);
  assign a_we = cmd_i.exec_single && (cmd_r == CMD_LOAD_A) && !a_full;
  assign b_we = cmd_i.exec_single && (cmd_r == CMD_LOAD_B) && !b_full;

  spam_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_POLY)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[IDX_W-1:0]),
    .wdata ({coef_in_r, expon_in_r}),
    .raddr (i_r[IDX_W-1:0]),
    .rdata (a_rdata)
  );

  spam_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_POLY)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[IDX_W-1:0]),
    .wdata ({coef_in_r, expon_in_r}),
    .raddr (j_r[IDX_W-1:0]),
    .rdata (b_rdata)
  );

  assign a_coef = a_rdata[TERM_W-1:EXPON_W];
  assign a_expon = a_rdata[EXPON_W-1:0];
  assign b_coef = b_rdata[TERM_W-1:EXPON_W];
  assign b_expon = b_rdata[EXPON_W-1:0];
  assign a_done = (i_r >= a_cnt_r);
  assign b_done = (j_r >= b_cnt_r);

  // The sum is exact in 33 bits; a mismatch of the top two bits means overflow.
  assign sum_full = {a_coef[COEF_W-1], a_coef} + {b_coef[COEF_W-1], b_coef};
  always_comb begin
    if (sum_full[COEF_W] != sum_full[COEF_W-1]) begin
      sat_sum = sum_full[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sat_sum = sum_full[COEF_W-1:0];
    end
  end

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    take_both = 1'b0;
    if (a_done && b_done) begin
      take_a = 1'b0;
    end else if (a_done) begin
      take_b = 1'b1;
    end else if (b_done) begin
      take_a = 1'b1;
    end else if (a_expon < b_expon) begin
      take_b = 1'b1;
    end else if (a_expon == b_expon) begin
      take_both = 1'b1;
    end else begin
      take_a = 1'b1;
    end
  end

  assign term_coef = take_both ? sat_sum : (take_a ? a_coef : b_coef);
  assign term_expon = take_b ? b_expon : a_expon;
  assign term_hit = take_a || take_b || (take_both && (sat_sum != '0));
  assign out_free = !out_vld_r || out_ready;

  assign stat_o.cmd = cmd_r;
  assign stat_o.both_done = a_done && b_done;
  assign stat_o.term_hit = term_hit;
  assign stat_o.pend_vld = pend_vld_r;
  assign stat_o.at_limit = (n_r == N_LAST);
  assign stat_o.out_free = out_free;

  always_comb begin
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    i_nxt = i_r;
    j_nxt = j_r;
    n_nxt = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_coef_nxt = pend_coef_r;
    pend_expon_nxt = pend_expon_r;
    out_vld_nxt = out_vld_r && !out_ready;
    out_coef_nxt = out_coef_r;
    out_expon_nxt = out_expon_r;
    out_status_nxt = out_status_r;
    out_last_nxt = out_last_r;

    if (cmd_i.exec_single) begin
      out_vld_nxt = 1'b1;
      out_coef_nxt = '0;
      out_expon_nxt = '0;
      out_last_nxt = 1'b1;
      out_status_nxt = ST_OK;
      unique case (cmd_r)
        CMD_LOAD_A: begin
          if (a_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            a_cnt_nxt = a_cnt_r + 1'b1;
          end
        end
        CMD_LOAD_B: begin
          if (b_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            b_cnt_nxt = b_cnt_r + 1'b1;
          end
        end
        CMD_CLEAR: begin
          a_cnt_nxt = '0;
          b_cnt_nxt = '0;
        end
        default: begin
          out_status_nxt = ST_OK;
        end
      endcase
    end

    if (cmd_i.merge_init) begin
      i_nxt = '0;
      j_nxt = '0;
      n_nxt = '0;
      pend_vld_nxt = 1'b0;
    end

    // The newest term is held back one step so the final one can carry is_last.
    if (cmd_i.merge_step) begin
      if (take_a || take_both) begin
        i_nxt = i_r + 1'b1;
      end
      if (take_b || take_both) begin
        j_nxt = j_r + 1'b1;
      end
      if (term_hit) begin
        n_nxt = n_r + 1'b1;
        pend_vld_nxt = 1'b1;
        pend_coef_nxt = term_coef;
        pend_expon_nxt = term_expon;
        if (pend_vld_r) begin
          out_vld_nxt = 1'b1;
          out_coef_nxt = pend_coef_r;
          out_expon_nxt = pend_expon_r;
          out_status_nxt = ST_TERM;
          out_last_nxt = 1'b0;
        end
      end
    end

    if (cmd_i.merge_final) begin
      out_vld_nxt = 1'b1;
      out_last_nxt = 1'b1;
      pend_vld_nxt = 1'b0;
      if (pend_vld_r) begin
        out_coef_nxt = pend_coef_r;
        out_expon_nxt = pend_expon_r;
        out_status_nxt = ST_TERM;
      end else begin
        out_coef_nxt = '0;
        out_expon_nxt = '0;
        out_status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      n_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      n_r <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r <= in_cmd;
      coef_in_r <= in_coef;
      expon_in_r <= in_expon;
    end
    pend_coef_r <= pend_coef_nxt;
    pend_expon_r <= pend_expon_nxt;
    out_coef_r <= out_coef_nxt;
    out_expon_r <= out_expon_nxt;
    out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_coef = out_coef_r;
  assign out_expon = out_expon_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;
endmodule

// ===== rtl/spam_ctrl.sv =====
// Controller: sequences loads, clears and the merge walk over both term stores.
module spam_ctrl import spam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.cmd == CMD_ADD) begin
          cmd_o.merge_init = 1'b1;
          state_nxt = S_FETCH;
        end else if (stat_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // Read addresses settle here; the store data is registered by the next cycle.
      S_FETCH: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (stat_i.both_done) begin
          state_nxt = S_FINAL;
        end else if (!(stat_i.term_hit && stat_i.pend_vld && !stat_i.out_free)) begin
          cmd_o.merge_step = 1'b1;
          state_nxt = (stat_i.term_hit && stat_i.at_limit) ? S_FINAL : S_FETCH;
        end
      end
      S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.merge_final = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== rtl/sparse_poly_add_merge_unit.sv =====
// Load/clear: one transaction in, one result; the command is captured, then the result registered.
// Add: each merge step is a store read, then a compare and add.
// is_last marks the final result of each command.
// A new transaction is accepted once the previous command has placed its last result.
// Synchronous active-low reset empties both stores (counts to zero) and the output register.
module sparse_poly_add_merge_unit import spam_pkg::*; #(
  parameter int TERMS_PER_POLY = TERMS_PER_POLY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  spam_in_if.sink    in_chan,
  spam_out_if.source out_chan
);
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  spam_dp #(.TERMS_PER_POLY(TERMS_PER_POLY)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .in_cmd     (in_chan.cmd),
    .in_coef    (in_chan.in_coef),
    .in_expon   (in_chan.in_expon),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_coef   (out_chan.out_coef),
    .out_expon  (out_chan.out_expon),
    .out_status (out_chan.status),
    .out_last   (out_chan.is_last)
  );
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sparse polynomial merge unit: directed table, then random merges.
module testbench import spam_pkg::*; ();

  localparam int TERMS = TERMS_PER_POLY_DEF;
  localparam int RANDOM_ITEMS = 370;
  localparam int DIR_ROWS = 27;
  localparam int SETTLE_CYCLES = 4 * TERMS + 16;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [EXPON_W-1:0] expon;
    logic [STATUS_W-1:0] status;
    logic last;
  } term_t;

  // A row is issued reps times; the exponent drops by two on each repetition.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [COEF_W-1:0] coef;
    logic [EXPON_W-1:0] expon;
    logic [4:0] reps;
    logic typed;
    logic [STATUS_W-1:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spam_in_if in_chan ();
  spam_out_if out_chan ();

  sparse_poly_add_merge_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always #2 clk = ~clk;

  // Mirror of the two term stores.
  logic [COEF_W-1:0] a_coef [TERMS];
  logic [EXPON_W-1:0] a_expon [TERMS];
  logic [COEF_W-1:0] b_coef [TERMS];
  logic [EXPON_W-1:0] b_expon [TERMS];
  int count_a = 0;
  int count_b = 0;

  term_t awaited_terms [$];
  int bad_count = 0;
  int items_sent = 0;
  int burst_left = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_ADD,    32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_EMPTY},
    '{CMD_LOAD_A, 32'h7FFF_FFFF, 16'hFFFF, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'h0000_0001, 16'hFFFF, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'h8000_0000, 16'h8000, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'hFFFF_FFFF, 16'h8000, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'h0001_0000, 16'h0032, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'hFFFF_0000, 16'h0032, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'h0000_0005, 16'h0028, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'hFFFF_FFF9, 16'h0000, 5'd1,  1'b1, ST_OK},
    '{CMD_ADD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, ST_TERM},
    '{CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_OK},
    '{CMD_ADD,    32'hFFFF_FFFF, 16'hFFFF, 5'd1,  1'b1, ST_EMPTY},
    '{CMD_LOAD_A, 32'h0003_0000, 16'h0003, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'hFFFD_0000, 16'h0003, 5'd1,  1'b1, ST_OK},
    '{CMD_ADD,    32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_EMPTY},
    '{CMD_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'h1234_5678, 16'h0005, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'h0000_0000, 16'h0009, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_B, 32'h4000_0000, 16'h0007, 5'd1,  1'b1, ST_OK},
    '{CMD_ADD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, ST_TERM},
    '{CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_OK},
    '{CMD_LOAD_A, 32'hAAAA_5555, 16'hFFF0, 5'd16, 1'b1, ST_OK},
    '{CMD_LOAD_A, 32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_FULL},
    '{CMD_LOAD_B, 32'h5555_AAAA, 16'hFFEF, 5'd16, 1'b1, ST_OK},
    '{CMD_LOAD_B, 32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_FULL},
    '{CMD_ADD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, ST_TERM},
    '{CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd1,  1'b1, ST_OK}
  };

  // Applies one command to the mirrored stores and returns the terms it should produce.
  function automatic int predict_command(input logic [CMD_W-1:0] cmd,
                                         input logic [COEF_W-1:0] coef,
                                         input logic [EXPON_W-1:0] expon,
                                         output term_t outs [MAX_RESULTS]);
    int i;
    int j;
    int n;
    bit keep;
    term_t cand;
    logic signed [COEF_W:0] total;
    i = 0;
    j = 0;
    n = 0;
    case (cmd) inside
      CMD_LOAD_A, CMD_LOAD_B: begin
        if ((cmd == CMD_LOAD_A ? count_a : count_b) >= TERMS) begin
          outs[0] = '{'0, '0, ST_FULL, 1'b1};
        end else begin
          if (cmd == CMD_LOAD_A) begin
            a_coef[count_a] = coef;
            a_expon[count_a] = expon;
            count_a++;
          end else begin
            b_coef[count_b] = coef;
            b_expon[count_b] = expon;
            count_b++;
          end
          outs[0] = '{'0, '0, ST_OK, 1'b1};
        end
        return 1;
      end
      CMD_CLEAR: begin
        count_a = 0;
        count_b = 0;
        outs[0] = '{'0, '0, ST_OK, 1'b1};
        return 1;
      end
      default: begin
        while (i < count_a || j < count_b) begin
          keep = 1'b1;
          if (j >= count_b || (i < count_a && a_expon[i] > b_expon[j])) begin
            cand = '{a_coef[i], a_expon[i], ST_TERM, 1'b0};
            i++;
          end else if (i >= count_a || a_expon[i] < b_expon[j]) begin
            cand = '{b_coef[j], b_expon[j], ST_TERM, 1'b0};
            j++;
          end else begin
            // Equal exponents: saturating sum, and a zero sum leaves no term.
            total = $signed({a_coef[i][COEF_W-1], a_coef[i]})
                  + $signed({b_coef[j][COEF_W-1], b_coef[j]});
            cand = '{total[COEF_W-1:0], a_expon[i], ST_TERM, 1'b0};
            if (total[COEF_W] != total[COEF_W-1])
              cand.coef = total[COEF_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            keep = (cand.coef != '0);
            i++;
            j++;
          end
          if (keep && n < MAX_RESULTS) begin
            outs[n] = cand;
            n++;
          end
        end
        if (n == 0) begin
          outs[0] = '{'0, '0, ST_EMPTY, 1'b1};
          return 1;
        end
        outs[n-1].last = 1'b1;
        return n;
      end
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return 32'($urandom_range(0, 131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  // Drives one transaction in bursts with random gaps, then records what it should produce.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [COEF_W-1:0] coef,
                               input logic [EXPON_W-1:0] expon, input bit typed,
                               input logic [STATUS_W-1:0] want);
    term_t outs [MAX_RESULTS];
    int n;
    int k;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.cmd <= cmd;
    in_chan.in_coef <= coef;
    in_chan.in_expon <= expon;
    do @(posedge clk); while (!in_chan.ready);
    n = predict_command(cmd, coef, expon, outs);
    if (typed) begin
      awaited_terms.push_back('{'0, '0, want, 1'b1});
    end else begin
      for (k = 0; k < n; k++) awaited_terms.push_back(outs[k]);
    end
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (awaited_terms.size() != 0) @(posedge clk);
  endtask

  // One random case: mostly well-formed sorted loads into both stores followed by an add,
  // with some raw noise, appends without a clear, overfilled stores and unsorted exponents.
  task automatic run_merge_case();
    logic [EXPON_W-1:0] pool_expon [32];
    logic [COEF_W-1:0] pool_a [32];
    logic [COEF_W-1:0] pool_b [32];
    bit in_a [32];
    bit in_b [32];
    int kind;
    int want_a;
    int want_b;
    int got_a;
    int got_b;
    int e;
    int step;
    int k;
    int ia;
    int ib;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(3, 10))
        issue_command(CMD_W'($urandom_range(0, 3)), $urandom,
                      EXPON_W'($urandom_range(0, 65535)), 1'b0, ST_TERM);
      return;
    end
    if (kind != 1)
      issue_command(CMD_CLEAR, $urandom, EXPON_W'($urandom_range(0, 65535)), 1'b0, ST_TERM);
    want_a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TERMS) : $urandom_range(0, 6);
    want_b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TERMS) : $urandom_range(0, 6);
    if (kind == 2) begin
      want_a = $urandom_range(TERMS - 2, TERMS + 4);
      want_b = $urandom_range(TERMS - 2, TERMS + 4);
    end
    e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(100, 65535);
    got_a = 0;
    got_b = 0;
    for (k = 0; k < 32; k++) begin
      pool_expon[k] = (kind == 3) ? 16'($urandom_range(0, 15)) : 16'(e);
      step = $urandom_range(1, 3);
      e = (e > step) ? e - step : 0;
      in_a[k] = (got_a < want_a) && ((kind == 2) ? ($urandom_range(0, 3) != 0)
                                                 : ($urandom_range(0, 1) != 0));
      in_b[k] = (got_b < want_b) && ((kind == 2) ? ($urandom_range(0, 3) != 0)
                                                 : ($urandom_range(0, 1) != 0));
      got_a += in_a[k];
      got_b += in_b[k];
      pool_a[k] = draw_coef();
      // Shared exponents sometimes carry opposite coefficients so that the sum cancels.
      pool_b[k] = (in_a[k] && $urandom_range(0, 2) == 0) ? -pool_a[k] : draw_coef();
    end
    ia = 0;
    ib = 0;
    while (ia < 32 || ib < 32) begin
      if (ib >= 32 || (ia < 32 && $urandom_range(0, 1) == 1)) begin
        if (in_a[ia]) issue_command(CMD_LOAD_A, pool_a[ia], pool_expon[ia], 1'b0, ST_TERM);
        ia++;
      end else begin
        if (in_b[ib]) issue_command(CMD_LOAD_B, pool_b[ib], pool_expon[ib], 1'b0, ST_TERM);
        ib++;
      end
    end
    issue_command(CMD_ADD, $urandom, EXPON_W'($urandom_range(0, 65535)), 1'b0, ST_TERM);
    // The add leaves both stores as they were, so a second one must repeat the result.
    if (kind == 4)
      issue_command(CMD_ADD, $urandom, EXPON_W'($urandom_range(0, 65535)), 1'b0, ST_TERM);
    if ($urandom_range(0, 5) == 0) wait_for_drain();
  endtask

  // Receiver back-pressure: picks a new ready pattern (always, random or periodic) after each random span.
  initial begin
    int mode;
    int span;
    int phase;
    phase = 0;
    out_chan.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        phase++;
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= 1'($urandom_range(0, 1));
          2: out_chan.ready <= (phase % 3 != 0);
          default: out_chan.ready <= (phase % 10 >= 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    term_t want;
    term_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.out_coef, out_chan.out_expon, out_chan.status, out_chan.is_last};
      if (awaited_terms.size() == 0) begin
        $display("%0t: unexpected result coef=%h expon=%h status=%0d last=%b",
                 $time, got.coef, got.expon, got.status, got.last);
        bad_count++;
      end else begin
        want = awaited_terms.pop_front();
        if (got.coef !== want.coef || got.expon !== want.expon ||
            got.status !== want.status || got.last !== want.last) begin
          $display("%0t: mismatch expected coef=%h expon=%h status=%0d last=%b", $time,
                   want.coef, want.expon, want.status, want.last);
          $display("%0t:          actual   coef=%h expon=%h status=%0d last=%b", $time,
                   got.coef, got.expon, got.status, got.last);
          bad_count++;
        end
      end
    end
  end

  initial begin
    int r;
    int k;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_LOAD_A;
    in_chan.in_coef = '0;
    in_chan.in_expon = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      for (k = 0; k < dir_rows[r].reps; k++)
        issue_command(dir_rows[r].cmd, dir_rows[r].coef, 16'(dir_rows[r].expon - 2 * k),
                      dir_rows[r].typed, dir_rows[r].want);
    end
    wait_for_drain();

    while (items_sent < RANDOM_ITEMS) run_merge_case();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
